### design/cpbb_pkg.sv
// Shared types, constants and helpers for the cubic path bounding box block.
package cpbb_pkg;

   localparam int CW          = 32;   // coordinate and matrix width
   localparam int FB          = 16;   // fraction bits
   localparam int ACC_W       = 2 * CW + 2;
   localparam int DW          = 31;   // normalised difference width
   localparam int NUM_REGS    = 6;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic signed [CW-1:0] ONE_Q = CW'(1) <<< FB;

   // item classes
   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_SEG  = 1'b1;

   // register indexes
   localparam logic [2:0] REG_A = 3'd0;
   localparam logic [2:0] REG_B = 3'd1;
   localparam logic [2:0] REG_C = 3'd2;
   localparam logic [2:0] REG_D = 3'd3;
   localparam logic [2:0] REG_E = 3'd4;
   localparam logic [2:0] REG_F = 3'd5;

   typedef struct packed {
      logic                 op;
      logic                 last;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic signed [CW-1:0] x2;
      logic signed [CW-1:0] y2;
      logic signed [CW-1:0] x3;
      logic signed [CW-1:0] y3;
   } item_type;

   typedef struct packed {
      logic signed [CW-1:0] a;
      logic signed [CW-1:0] b;
      logic signed [CW-1:0] c;
      logic signed [CW-1:0] d;
      logic signed [CW-1:0] e;
      logic signed [CW-1:0] f;
   } matrix_type;

   typedef struct packed {
      logic signed [CW-1:0] min_x;
      logic signed [CW-1:0] min_y;
      logic signed [CW-1:0] max_x;
      logic signed [CW-1:0] max_y;
      logic                 empty_res;
   } box_type;

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (CW - 1)) - ACC_W'(1);
      lo = -(ACC_W'(1) <<< (CW - 1));
      if (v > hi) begin
         return hi[CW-1:0];
      end else if (v < lo) begin
         return lo[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

endpackage

### design/cpbb_csr.sv
// Transform matrix registers behind the APB-style configuration port.
module cpbb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cpbb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cpbb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cpbb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output cpbb_pkg::matrix_type                mat
);

   cpbb_pkg::matrix_type mat_ff, mat_in;
   logic [2:0]           idx;
   logic                 wr;

   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign mat        = mat_ff;

   always_comb begin
      mat_in = mat_ff;
      if (wr) begin
         case (idx)
            cpbb_pkg::REG_A: mat_in.a = csr_pwdata;
            cpbb_pkg::REG_B: mat_in.b = csr_pwdata;
            cpbb_pkg::REG_C: mat_in.c = csr_pwdata;
            cpbb_pkg::REG_D: mat_in.d = csr_pwdata;
            cpbb_pkg::REG_E: mat_in.e = csr_pwdata;
            cpbb_pkg::REG_F: mat_in.f = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         cpbb_pkg::REG_A: csr_prdata = mat_ff.a;
         cpbb_pkg::REG_B: csr_prdata = mat_ff.b;
         cpbb_pkg::REG_C: csr_prdata = mat_ff.c;
         cpbb_pkg::REG_D: csr_prdata = mat_ff.d;
         cpbb_pkg::REG_E: csr_prdata = mat_ff.e;
         cpbb_pkg::REG_F: csr_prdata = mat_ff.f;
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff   <= '0;
         mat_ff.a <= cpbb_pkg::ONE_Q;
         mat_ff.d <= cpbb_pkg::ONE_Q;
      end else begin
         mat_ff <= mat_in;
      end
   end

endmodule

### design/cpbb_front.sv
// Input side: takes beats, classifies them and queues them for the solver.
module cpbb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic signed [31:0]           req_x1,
   input  logic signed [31:0]           req_y1,
   input  logic signed [31:0]           req_x2,
   input  logic signed [31:0]           req_y2,
   input  logic signed [31:0]           req_x3,
   input  logic signed [31:0]           req_y3,
   input  logic                         req_last,
   output logic                         item_valid,
   output cpbb_pkg::item_type           item,
   input  logic                         item_pop
);

   cpbb_pkg::item_type q0_ff, q0_in, q1_ff, q1_in, beat;
   logic               wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               push;

   assign req_ready  = (cnt_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = rd_ff ? q1_ff : q0_ff;

   always_comb begin
      beat.op   = req_mode ? cpbb_pkg::OP_SEG : cpbb_pkg::OP_MOVE;
      beat.last = req_last;
      beat.x1   = req_x1;
      beat.y1   = req_y1;
      beat.x2   = req_x2;
      beat.y2   = req_y2;
      beat.x3   = req_x3;
      beat.y3   = req_y3;
   end

   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         if (wr_ff) begin
            q1_in = beat;
         end else begin
            q0_in = beat;
         end
         wr_in = !wr_ff;
      end
      if (item_pop && item_valid) begin
         rd_in = !rd_ff;
      end
      cnt_in = cnt_ff + 2'(push) - 2'(item_pop && item_valid);
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### design/cpbb_back.sv
// Solver: transform, per-axis extremum search, curve evaluation and box tracking.
module cpbb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  cpbb_pkg::item_type   item,
   output logic                 item_pop,
   input  cpbb_pkg::matrix_type mat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cpbb_pkg::box_type    rsp_box
);

   localparam int CW = cpbb_pkg::CW;
   localparam int FB = cpbb_pkg::FB;
   localparam int AW = cpbb_pkg::ACC_W;
   localparam int DW = cpbb_pkg::DW;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_XF    = 4'd1;
   localparam logic [3:0] S_INIT  = 4'd2;
   localparam logic [3:0] S_DIFF  = 4'd3;
   localparam logic [3:0] S_DISC0 = 4'd4;
   localparam logic [3:0] S_DISC1 = 4'd5;
   localparam logic [3:0] S_DISC2 = 4'd6;
   localparam logic [3:0] S_SQRT  = 4'd7;
   localparam logic [3:0] S_ROOT  = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_LERP  = 4'd10;
   localparam logic [3:0] S_BOX   = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   logic [3:0]              st_ff, st_in;
   logic [4:0]              k_ff, k_in;
   cpbb_pkg::item_type      it_ff, it_in;
   logic signed [67:0]      prod_ff;
   logic signed [AW-1:0]    acc_ff, acc_in;
   logic signed [CW-1:0]    px0_ff, px1_ff, px2_ff, px3_ff, py0_ff, py1_ff, py2_ff, py3_ff;
   logic signed [CW-1:0]    px0_in, px1_in, px2_in, px3_in, py0_in, py1_in, py2_in, py3_in;
   logic signed [CW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CW-1:0]    lox_ff, lox_in, hix_ff, hix_in, loy_ff, loy_in, hiy_ff, hiy_in;
   logic                    axis_ff, axis_in, lin_ff, lin_in, ri_ff, ri_in;
   logic signed [DW-1:0]    d1_ff, d1_in, d2_ff, d2_in, d3_ff, d3_in;
   logic signed [32:0]      a_ff, a_in;
   logic signed [61:0]      sq_ff, sq_in;
   logic [59:0]             v_ff, v_in, r_ff, r_in;
   logic [34:0]             rem_ff, rem_in, den_ff, den_in;
   logic [FB-1:0]           t_ff, t_in;
   logic signed [CW-1:0]    la_ff, la_in, lb_ff, lb_in, lc_ff, lc_in;
   logic signed [CW-1:0]    bminx_ff, bminx_in, bminy_ff, bminy_in;
   logic signed [CW-1:0]    bmaxx_ff, bmaxx_in, bmaxy_ff, bmaxy_in;
   logic                    bvalid_ff, bvalid_in;
   cpbb_pkg::box_type       rsp_ff, rsp_in;
   logic                    rspv_ff, rspv_in;

   logic signed [33:0]      mul_a, mul_b;
   logic signed [67:0]      mul_p;

   assign mul_p     = mul_a * mul_b;
   assign rsp_valid = rspv_ff;
   assign rsp_box   = rsp_ff;
   assign item_pop  = (st_ff == S_IDLE) && item_valid;

   // selected axis control points
   logic signed [CW-1:0] p0, p1, p2, p3;
   assign p0 = axis_ff ? py0_ff : px0_ff;
   assign p1 = axis_ff ? py1_ff : px1_ff;
   assign p2 = axis_ff ? py2_ff : px2_ff;
   assign p3 = axis_ff ? py3_ff : px3_ff;

   always_comb begin
      logic [4:0]           kp;
      logic [4:0]           n_mul;
      logic signed [CW-1:0] in_x, in_y, off, xr, pa, pb, lv;
      logic signed [AW-1:0] sum, xt;
      logic signed [32:0]   e1, e2, e3, dd;
      logic [32:0]          m1, m2, m3, mm;
      logic [2:0]           s;
      logic signed [32:0]   n1, n2, n3;
      logic signed [61:0]   disc;
      logic [5:0]           sh;
      logic [59:0]          bitv, trial;
      logic signed [34:0]   base, rr, num, den;
      logic                 skip;
      logic [35:0]          rem2;
      logic                 ge;
      logic [FB-1:0]        t_n;
      logic [2:0]           j;
      logic signed [67:0]   pshift;
      logic signed [33:0]   res34;
      logic                 adv, next_axis;

      st_in = st_ff;  k_in = k_ff;  it_in = it_ff;  acc_in = acc_ff;
      px0_in = px0_ff; px1_in = px1_ff; px2_in = px2_ff; px3_in = px3_ff;
      py0_in = py0_ff; py1_in = py1_ff; py2_in = py2_ff; py3_in = py3_ff;
      cx_in = cx_ff; cy_in = cy_ff;
      lox_in = lox_ff; hix_in = hix_ff; loy_in = loy_ff; hiy_in = hiy_ff;
      axis_in = axis_ff; lin_in = lin_ff; ri_in = ri_ff;
      d1_in = d1_ff; d2_in = d2_ff; d3_in = d3_ff; a_in = a_ff; sq_in = sq_ff;
      v_in = v_ff; r_in = r_ff; rem_in = rem_ff; den_in = den_ff; t_in = t_ff;
      la_in = la_ff; lb_in = lb_ff; lc_in = lc_ff;
      bminx_in = bminx_ff; bminy_in = bminy_ff; bmaxx_in = bmaxx_ff; bmaxy_in = bmaxy_ff;
      bvalid_in = bvalid_ff; rsp_in = rsp_ff; rspv_in = rspv_ff;
      mul_a = '0; mul_b = '0;
      adv = 1'b0; next_axis = 1'b0;

      kp    = k_ff - 5'd1;
      n_mul = (it_ff.op == cpbb_pkg::OP_SEG) ? 5'd12 : 5'd4;
      case (k_ff[3:2])
         2'd0:    begin in_x = it_ff.x1; in_y = it_ff.y1; end
         2'd1:    begin in_x = it_ff.x2; in_y = it_ff.y2; end
         default: begin in_x = it_ff.x3; in_y = it_ff.y3; end
      endcase
      off  = kp[1] ? mat.f : mat.e;
      sum  = acc_ff + prod_ff[AW-1:0];
      xt   = (sum >>> FB) + AW'(off);
      xr   = cpbb_pkg::sat_coord(xt);

      e1 = 33'(p1) - 33'(p0);
      e2 = 33'(p2) - 33'(p1);
      e3 = 33'(p3) - 33'(p2);
      m1 = e1[32] ? 33'(-e1) : 33'(e1);
      m2 = e2[32] ? 33'(-e2) : 33'(e2);
      m3 = e3[32] ? 33'(-e3) : 33'(e3);
      mm = (m1 > m2) ? m1 : m2;
      mm = (m3 > mm) ? m3 : mm;
      if (mm >= (33'd1 << 32))      s = 3'd4;
      else if (mm >= (33'd1 << 31)) s = 3'd3;
      else if (mm >= (33'd1 << 30)) s = 3'd2;
      else if (mm >= (33'd1 << 29)) s = 3'd1;
      else                          s = 3'd0;
      n1 = e1 >>> s;
      n2 = e2 >>> s;
      n3 = e3 >>> s;

      disc = sq_ff - prod_ff[61:0];

      sh    = 6'd58 - {k_ff, 1'b0};
      bitv  = 60'd1 << sh;
      trial = r_ff + bitv;

      base = 35'(d1_ff) - 35'(d2_ff);
      rr   = 35'(r_ff[30:0]);
      if (lin_ff) begin
         num = 35'(d1_ff);
         den = base <<< 1;
      end else begin
         num = ri_ff ? (base - rr) : (base + rr);
         den = 35'(a_ff);
      end
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      skip = (den == 0) || (num <= 0) || (num >= den);

      rem2 = {rem_ff, 1'b0};
      ge   = rem2 >= {1'b0, den_ff};
      t_n  = {t_ff[FB-2:0], ge};

      j = k_ff[3:1];
      case (j)
         3'd0:    begin pa = p0;    pb = p1;    end
         3'd1:    begin pa = p1;    pb = p2;    end
         3'd2:    begin pa = p2;    pb = p3;    end
         3'd3:    begin pa = la_ff; pb = lb_ff; end
         3'd4:    begin pa = lb_ff; pb = lc_ff; end
         default: begin pa = la_ff; pb = lb_ff; end
      endcase
      dd     = 33'(pb) - 33'(pa);
      pshift = prod_ff >>> FB;
      res34  = 34'(pa) + pshift[33:0];
      lv     = res34[CW-1:0];

      case (st_ff)
         S_IDLE: begin
            if (item_valid) begin
               it_in  = item;
               px0_in = cx_ff;
               py0_in = cy_ff;
               k_in   = 5'd0;
               st_in  = S_XF;
            end
         end
         S_XF: begin
            if (k_ff < n_mul) begin
               mul_a = k_ff[0] ? 34'(in_y) : 34'(in_x);
               if (k_ff[1]) mul_b = k_ff[0] ? 34'(mat.d) : 34'(mat.b);
               else         mul_b = k_ff[0] ? 34'(mat.c) : 34'(mat.a);
            end
            if (k_ff != 5'd0) begin
               if (!kp[0]) begin
                  acc_in = prod_ff[AW-1:0];
               end else begin
                  case (kp[3:1])
                     3'd0:    px1_in = xr;
                     3'd1:    py1_in = xr;
                     3'd2:    px2_in = xr;
                     3'd3:    py2_in = xr;
                     3'd4:    px3_in = xr;
                     default: py3_in = xr;
                  endcase
               end
            end
            k_in = k_ff + 5'd1;
            if (k_ff == n_mul) st_in = S_INIT;
         end
         S_INIT: begin
            if (it_ff.op == cpbb_pkg::OP_MOVE) begin
               cx_in = px1_ff;
               cy_in = py1_ff;
               st_in = S_FIN;
            end else begin
               lox_in  = (px0_ff < px3_ff) ? px0_ff : px3_ff;
               hix_in  = (px0_ff < px3_ff) ? px3_ff : px0_ff;
               loy_in  = (py0_ff < py3_ff) ? py0_ff : py3_ff;
               hiy_in  = (py0_ff < py3_ff) ? py3_ff : py0_ff;
               axis_in = 1'b0;
               st_in   = S_DIFF;
            end
         end
         S_DIFF: begin
            d1_in = n1[DW-1:0];
            d2_in = n2[DW-1:0];
            d3_in = n3[DW-1:0];
            a_in  = n1 - (n2 <<< 1) + n3;
            st_in = S_DISC0;
         end
         S_DISC0: begin
            mul_a = 34'(d2_ff);
            mul_b = 34'(d2_ff);
            st_in = S_DISC1;
         end
         S_DISC1: begin
            mul_a = 34'(d1_ff);
            mul_b = 34'(d3_ff);
            sq_in = prod_ff[61:0];
            st_in = S_DISC2;
         end
         S_DISC2: begin
            lin_in = 1'b0;
            ri_in  = 1'b0;
            if (a_ff != 0) begin
               if (!disc[61] && disc != 0) begin
                  v_in  = disc[59:0];
                  r_in  = '0;
                  k_in  = 5'd0;
                  st_in = S_SQRT;
               end else begin
                  next_axis = 1'b1;
               end
            end else if (d1_ff != d2_ff) begin
               lin_in = 1'b1;
               st_in  = S_ROOT;
            end else begin
               next_axis = 1'b1;
            end
         end
         S_SQRT: begin
            // one result bit per cycle, floor square root
            if (v_ff >= trial) begin
               v_in = v_ff - trial;
               r_in = (r_ff >> 1) + bitv;
            end else begin
               r_in = r_ff >> 1;
            end
            k_in = k_ff + 5'd1;
            if (k_ff == 5'd29) st_in = S_ROOT;
         end
         S_ROOT: begin
            if (skip) begin
               adv = 1'b1;
            end else begin
               rem_in = num;
               den_in = den;
               t_in   = '0;
               k_in   = 5'd0;
               st_in  = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = ge ? 35'(rem2 - {1'b0, den_ff}) : rem2[34:0];
            t_in   = t_n;
            k_in   = k_ff + 5'd1;
            if (k_ff == 5'(FB - 1)) begin
               k_in = 5'd0;
               if (t_n == '0) adv = 1'b1;
               else           st_in = S_LERP;
            end
         end
         S_LERP: begin
            if (!k_ff[0]) begin
               mul_a = 34'(dd);
               mul_b = 34'(t_ff);
            end else begin
               case (j)
                  3'd0, 3'd3: la_in = lv;
                  3'd1, 3'd4: lb_in = lv;
                  3'd2:       lc_in = lv;
                  default: begin
                     if (axis_ff) begin
                        if (lv < loy_ff) loy_in = lv;
                        if (lv > hiy_ff) hiy_in = lv;
                     end else begin
                        if (lv < lox_ff) lox_in = lv;
                        if (lv > hix_ff) hix_in = lv;
                     end
                  end
               endcase
            end
            k_in = k_ff + 5'd1;
            if (k_ff == 5'd11) adv = 1'b1;
         end
         S_BOX: begin
            if (!bvalid_ff) begin
               bminx_in = lox_ff; bmaxx_in = hix_ff;
               bminy_in = loy_ff; bmaxy_in = hiy_ff;
            end else begin
               if (lox_ff < bminx_ff) bminx_in = lox_ff;
               if (hix_ff > bmaxx_ff) bmaxx_in = hix_ff;
               if (loy_ff < bminy_ff) bminy_in = loy_ff;
               if (hiy_ff > bmaxy_ff) bmaxy_in = hiy_ff;
            end
            bvalid_in = 1'b1;
            cx_in     = px3_ff;
            cy_in     = py3_ff;
            st_in     = S_FIN;
         end
         S_FIN: begin
            if (!it_ff.last) begin
               st_in = S_IDLE;
            end else if (!rspv_ff || rsp_ready) begin
               if (bvalid_ff) begin
                  rsp_in.min_x     = bminx_ff;
                  rsp_in.min_y     = bminy_ff;
                  rsp_in.max_x     = bmaxx_ff;
                  rsp_in.max_y     = bmaxy_ff;
                  rsp_in.empty_res = 1'b0;
               end else begin
                  rsp_in           = '0;
                  rsp_in.empty_res = 1'b1;
               end
               bminx_in  = '0; bminy_in = '0; bmaxx_in = '0; bmaxy_in = '0;
               bvalid_in = 1'b0;
               st_in     = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase

      if (adv) begin
         if (!lin_ff && !ri_ff) begin
            ri_in = 1'b1;
            st_in = S_ROOT;
         end else begin
            next_axis = 1'b1;
         end
      end
      if (next_axis) begin
         if (!axis_ff) begin
            axis_in = 1'b1;
            st_in   = S_DIFF;
         end else begin
            st_in = S_BOX;
         end
      end

      if (st_ff == S_FIN && it_ff.last && (!rspv_ff || rsp_ready)) begin
         rspv_in = 1'b1;
      end else if (rsp_ready) begin
         rspv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      it_ff   <= it_in;   k_ff   <= k_in;   acc_ff <= acc_in;
      px0_ff  <= px0_in;  px1_ff <= px1_in; px2_ff <= px2_in; px3_ff <= px3_in;
      py0_ff  <= py0_in;  py1_ff <= py1_in; py2_ff <= py2_in; py3_ff <= py3_in;
      lox_ff  <= lox_in;  hix_ff <= hix_in; loy_ff <= loy_in; hiy_ff <= hiy_in;
      lin_ff  <= lin_in;  ri_ff  <= ri_in;  axis_ff <= axis_in;
      d1_ff   <= d1_in;   d2_ff  <= d2_in;  d3_ff  <= d3_in;  a_ff <= a_in;
      sq_ff   <= sq_in;   v_ff   <= v_in;   r_ff   <= r_in;
      rem_ff  <= rem_in;  den_ff <= den_in; t_ff   <= t_in;
      la_ff   <= la_in;   lb_ff  <= lb_in;  lc_ff  <= lc_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         st_ff     <= S_IDLE;
         rspv_ff   <= 1'b0;
         bvalid_ff <= 1'b0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         bminx_ff  <= '0;
         bminy_ff  <= '0;
         bmaxx_ff  <= '0;
         bmaxy_ff  <= '0;
      end else begin
         st_ff     <= st_in;
         rspv_ff   <= rspv_in;
         bvalid_ff <= bvalid_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         bminx_ff  <= bminx_in;
         bminy_ff  <= bminy_in;
         bmaxx_ff  <= bmaxx_in;
         bmaxy_ff  <= bmaxy_in;
      end
   end

   // a box beat appears only as a last item finishes
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rspv_ff) |-> ($past(st_ff) == S_FIN && $past(it_ff.last)))
      else $error("result beat without a finishing last item");

   // evaluation only ever runs on a parameter strictly inside the segment
   a_t_open: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_LERP) |-> (t_ff != '0))
      else $error("curve evaluated at t of zero");

   // square root of a disc below 2^60 must fit in 30 bits
   a_sqrt_rng: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_ROOT && !lin_ff) |-> (r_ff < (60'd1 << 30)))
      else $error("square root out of range");

endmodule

### design/cubic_path_bounding_box_top.sv
// Cubic path bounding box: top level tying the register port, queue and solver.
//
// Items are queued two deep by the front end; the solver works on one item at a
// time. A move-to transforms its one point. A segment transforms its three points
// (one 32x32 product per cycle through the single shared multiplier), then, per
// axis, runs the set-up steps, a bit-serial square root when the derivative is
// quadratic, and for each root a check step, the bit-serial divider and six
// evaluation steps, then merges the box and finishes. A last item holds in its
// final cycle until the result register is free.
module cubic_path_bounding_box_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic signed [31:0]              req_x1,
   input  logic signed [31:0]              req_y1,
   input  logic signed [31:0]              req_x2,
   input  logic signed [31:0]              req_y2,
   input  logic signed [31:0]              req_x3,
   input  logic signed [31:0]              req_y3,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_min_x,
   output logic signed [31:0]              rsp_min_y,
   output logic signed [31:0]              rsp_max_x,
   output logic signed [31:0]              rsp_max_y,
   output logic                            rsp_empty_res,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cpbb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cpbb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cpbb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   cpbb_pkg::matrix_type mat;
   cpbb_pkg::item_type   item;
   cpbb_pkg::box_type    box;
   logic                 item_valid, item_pop;

   cpbb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mat         (mat)
   );

   cpbb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_x1     (req_x1),
      .req_y1     (req_y1),
      .req_x2     (req_x2),
      .req_y2     (req_y2),
      .req_x3     (req_x3),
      .req_y3     (req_y3),
      .req_last   (req_last),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   cpbb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .mat        (mat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_box    (box)
   );

   assign rsp_min_x     = box.min_x;
   assign rsp_min_y     = box.min_y;
   assign rsp_max_x     = box.max_x;
   assign rsp_max_y     = box.max_y;
   assign rsp_empty_res = box.empty_res;

endmodule

### dv/tb_cubic_path_bounding_box_top.sv
// Self-checking testbench for the cubic path bounding box block.
`timescale 1ns / 100ps

module tb_cubic_path_bounding_box_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = cpbb_pkg::OP_MOVE;
   logic signed [31:0] req_x1 = '0, req_y1 = '0, req_x2 = '0, req_y2 = '0;
   logic signed [31:0] req_x3 = '0, req_y3 = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_min_x, rsp_min_y, rsp_max_x, rsp_max_y;
   logic rsp_empty_res;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [cpbb_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [cpbb_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [cpbb_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   cubic_path_bounding_box_top u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #400ms;
      $display("Regression FAIL");
      $finish;
   end

   // predictor state
   longint mat [6];
   longint cur_x, cur_y, bmin_x, bmin_y, bmax_x, bmax_y;
   bit     bvalid;
   cpbb_pkg::box_type boxes_due [$];
   int errors = 0, mismatches = 0, boxes_seen = 0, segs_sent = 0;
   int stall_phase = 0;

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint map_term(longint u, longint p, longint w, longint q,
                                       longint r);
      longint m1, m2, h1, h2;
      m1 = u * p;
      m2 = w * q;
      h1 = fshift(m1, cpbb_pkg::FB);
      h2 = fshift(m2, cpbb_pkg::FB);
      return sat32(h1 + h2 + r + fshift((m1 - (h1 << cpbb_pkg::FB)) +
                                        (m2 - (h2 << cpbb_pkg::FB)), cpbb_pkg::FB));
   endfunction

   function automatic longint floor_root(longint v);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint blend(longint p, longint q, longint t);
      return p + fshift((q - p) * t, cpbb_pkg::FB);
   endfunction

   function automatic void widen_at(longint num, longint den, longint p[4],
                                    inout longint lo, inout longint hi);
      longint t, a, b, c, v;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (den == 0 || num <= 0 || num >= den) return;
      t = (num << cpbb_pkg::FB) / den;
      if (t <= 0 || t >= (64'sd1 << cpbb_pkg::FB)) return;
      a = blend(p[0], p[1], t);
      b = blend(p[1], p[2], t);
      c = blend(p[2], p[3], t);
      a = blend(a, b, t);
      b = blend(b, c, t);
      v = blend(a, b, t);
      if (v < lo) lo = v;
      if (v > hi) hi = v;
   endfunction

   function automatic longint absval(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void axis_bounds(longint p[4], inout longint lo, inout longint hi);
      longint d1, d2, d3, m, a, disc, r;
      int s;
      d1 = p[1] - p[0];
      d2 = p[2] - p[1];
      d3 = p[3] - p[2];
      m = absval(d1);
      if (absval(d2) > m) m = absval(d2);
      if (absval(d3) > m) m = absval(d3);
      s = 0;
      while ((m >> s) >= (64'sd1 << 29)) s++;
      d1 = fshift(d1, s);
      d2 = fshift(d2, s);
      d3 = fshift(d3, s);
      a = d1 - 2 * d2 + d3;
      if (a != 0) begin
         disc = d2 * d2 - d1 * d3;
         if (disc > 0) begin
            r = floor_root(disc);
            widen_at(d1 - d2 + r, a, p, lo, hi);
            widen_at(d1 - d2 - r, a, p, lo, hi);
         end
      end else if (d1 != d2) begin
         widen_at(d1, 2 * (d1 - d2), p, lo, hi);
      end
   endfunction

   function automatic void map_point(longint x, longint y, output longint ox,
                                     output longint oy);
      ox = map_term(x, mat[cpbb_pkg::REG_A], y, mat[cpbb_pkg::REG_C], mat[cpbb_pkg::REG_E]);
      oy = map_term(x, mat[cpbb_pkg::REG_B], y, mat[cpbb_pkg::REG_D], mat[cpbb_pkg::REG_F]);
   endfunction

   function automatic void predict_box(cpbb_pkg::item_type it);
      longint px[4], py[4], lx, hx, ly, hy;
      cpbb_pkg::box_type b;
      if (it.op == cpbb_pkg::OP_SEG) begin
         px[0] = cur_x;
         py[0] = cur_y;
         map_point(it.x1, it.y1, px[1], py[1]);
         map_point(it.x2, it.y2, px[2], py[2]);
         map_point(it.x3, it.y3, px[3], py[3]);
         lx = px[0] < px[3] ? px[0] : px[3];
         hx = px[0] < px[3] ? px[3] : px[0];
         ly = py[0] < py[3] ? py[0] : py[3];
         hy = py[0] < py[3] ? py[3] : py[0];
         axis_bounds(px, lx, hx);
         axis_bounds(py, ly, hy);
         if (!bvalid) begin
            bmin_x = lx; bmax_x = hx; bmin_y = ly; bmax_y = hy;
            bvalid = 1'b1;
         end else begin
            if (lx < bmin_x) bmin_x = lx;
            if (hx > bmax_x) bmax_x = hx;
            if (ly < bmin_y) bmin_y = ly;
            if (hy > bmax_y) bmax_y = hy;
         end
         cur_x = px[3];
         cur_y = py[3];
      end else begin
         map_point(it.x1, it.y1, cur_x, cur_y);
      end
      if (!it.last) return;
      b.min_x = bmin_x[31:0];
      b.min_y = bmin_y[31:0];
      b.max_x = bmax_x[31:0];
      b.max_y = bmax_y[31:0];
      b.empty_res = !bvalid;
      if (!bvalid) b = '{0, 0, 0, 0, 1'b1};
      boxes_due.push_back(b);
      bmin_x = 0; bmin_y = 0; bmax_x = 0; bmax_y = 0;
      bvalid = 1'b0;
   endfunction

   // result side: stall pattern, compare each beat against the oldest box
   always @(posedge clock) begin
      cpbb_pkg::box_type got, want;
      if (!reset) begin
         stall_phase <= stall_phase + 1;
         rsp_ready <= (stall_phase % 64) < 40 ? 1'b1 : (($urandom & 3) == 0);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_min_x, rsp_min_y, rsp_max_x, rsp_max_y, rsp_empty_res};
            boxes_seen <= boxes_seen + 1;
            if (boxes_due.size() == 0) begin
               errors <= errors + 1;
               $display("unexpected box beat %h", got);
            end else begin
               want = boxes_due.pop_front();
               if (got !== want) begin
                  errors <= errors + 1;
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("box mismatch: exp %h %h %h %h e%b, got %h %h %h %h e%b",
                        want.min_x, want.min_y, want.max_x, want.max_y, want.empty_res,
                        got.min_x, got.min_y, got.max_x, got.max_y, got.empty_res);
               end
            end
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      mat[idx] = longint'(signed'(val));
      @(posedge clock);
   endtask

   task automatic load_matrix(logic [31:0] a, b, c, d, e, f);
      write_reg(cpbb_pkg::REG_A, a); write_reg(cpbb_pkg::REG_B, b);
      write_reg(cpbb_pkg::REG_C, c); write_reg(cpbb_pkg::REG_D, d);
      write_reg(cpbb_pkg::REG_E, e); write_reg(cpbb_pkg::REG_F, f);
   endtask

   task automatic send_item(cpbb_pkg::item_type it);
      req_valid <= 1'b1;
      req_mode <= it.op;
      req_last <= it.last;
      req_x1 <= it.x1; req_y1 <= it.y1; req_x2 <= it.x2;
      req_y2 <= it.y2; req_x3 <= it.x3; req_y3 <= it.y3;
      // ready comes from registers only, so it is steady mid-cycle
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      predict_box(it);
      if (it.op == cpbb_pkg::OP_SEG) segs_sent++;
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (boxes_due.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int kind);
      case (kind)
         0: return $urandom;
         1: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
         default: return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
      endcase
   endfunction

   function automatic cpbb_pkg::item_type rand_item(bit seg, bit fin, int kind);
      cpbb_pkg::item_type it;
      it.op = seg ? cpbb_pkg::OP_SEG : cpbb_pkg::OP_MOVE;
      it.last = fin;
      it.x1 = rand_coord(kind); it.y1 = rand_coord(kind);
      it.x2 = rand_coord(kind); it.y2 = rand_coord(kind);
      it.x3 = rand_coord(kind); it.y3 = rand_coord(kind);
      return it;
   endfunction

   localparam logic signed [31:0] PMAX = 32'sh7fffffff;
   localparam logic signed [31:0] PMIN = 32'sh80000000;
   localparam logic signed [31:0] U1 = 32'sh00010000;
   localparam logic OM = cpbb_pkg::OP_MOVE;
   localparam logic OS = cpbb_pkg::OP_SEG;

   // directed rows: empty emission, segment from origin, extrema, loops, lines
   cpbb_pkg::item_type dir_rows [] = '{
      '{OM, 1'b1, 0, 0, 0, 0, 0, 0},
      '{OS, 1'b1, 0, 0, 0, 0, 0, 0},
      '{OS, 1'b1, U1, 2*U1, 2*U1, -U1, 3*U1, U1},
      '{OM, 1'b0, -U1, -U1, 0, 0, 0, 0},
      '{OS, 1'b0, 0, 4*U1, 4*U1, 4*U1, 4*U1, 0},
      '{OS, 1'b1, 8*U1, -6*U1, -5*U1, 7*U1, 0, 0},
      '{OM, 1'b0, PMIN, PMIN, PMAX, PMAX, PMAX, PMAX},
      '{OS, 1'b1, PMAX, PMAX, PMIN, PMIN, PMAX, PMAX},
      '{OM, 1'b0, PMAX, PMIN, 0, 0, 0, 0},
      '{OS, 1'b1, PMIN, PMAX, PMAX, PMIN, PMIN, PMAX},
      '{OM, 1'b0, 0, 0, 0, 0, 0, 0},
      '{OS, 1'b0, U1, U1, 2*U1, 2*U1, 3*U1, 3*U1},
      '{OS, 1'b0, 3*U1, 3*U1, 3*U1, 3*U1, 3*U1, 3*U1},
      '{OS, 1'b0, 5*U1, 0, -2*U1, 0, 3*U1, 9*U1},
      '{OM, 1'b1, 7, -7, 0, 0, 0, 0},
      '{OS, 1'b1, -1, 1, 32'sh1, 32'shffff, 32'sh7fff0000, -1},
      '{OM, 1'b1, 0, 0, 0, 0, 0, 0}
   };

   initial begin
      int n, shape_len, kind;
      bit fin;
      mat = '{65536, 0, 0, 65536, 0, 0};
      cur_x = 0; cur_y = 0; bmin_x = 0; bmin_y = 0; bmax_x = 0; bmax_y = 0;
      bvalid = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // result of an empty shape after reset is known outright
      boxes_due.push_back('{0, 0, 0, 0, 1'b1});
      cur_x = 0; // reset state retained
      send_item(dir_rows[0]);
      boxes_due.pop_back();  // predictor adds its own copy
      foreach (dir_rows[i]) begin
         if (i == 0) continue;
         send_item(dir_rows[i]);
      end
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_matrix(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                           32'h7fffffff, 32'h80000000);
            1: load_matrix(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                           32'h80000000, 32'h7fffffff);
            2: load_matrix(0, 0, 0, 0, 0, 0);
            3: load_matrix(32'h00010000, 0, 0, 32'h00010000, 0, 0);
            default: load_matrix($urandom_range(0, 1 << 18) - (1 << 17), $urandom_range(0,
                        1 << 17) - (1 << 16), $urandom_range(0, 1 << 17) - (1 << 16),
                        $urandom_range(0, 1 << 18) - (1 << 17), $urandom, $urandom);
         endcase
         n = (phase < 3) ? 60 : 320;
         while (n > 0) begin
            shape_len = $urandom_range(1, 6);
            kind = $urandom_range(0, 2);
            // mostly move-to then segments; some shapes open without a move-to
            if ($urandom_range(0, 4) != 0) begin
               send_item(rand_item(1'b0, 1'b0, kind));
               n--;
            end
            for (int k = 0; k < shape_len; k++) begin
               fin = (k == shape_len - 1);
               send_item(rand_item($urandom_range(0, 7) != 0, fin, kind));
               n--;
               if ($urandom_range(0, 3) == 0) pause_sender();
            end
         end
         drain();
      end

      $display("Checked %0d boxes from %0d segments over six transform settings.",
         boxes_seen, segs_sent);
      if (errors == 0 && boxes_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
